@@ rtl/ptmt_pkg.sv @@
`default_nettype none

package ptmt_pkg;

    typedef enum logic [2:0] {
        FUNC_HOME        = 3'd0,
        FUNC_STOP        = 3'd1,
        FUNC_JOG         = 3'd2,
        FUNC_PAN_ANGLE   = 3'd3,
        FUNC_TILT_ANGLE  = 3'd4,
        FUNC_PAN_REPORT  = 3'd5,
        FUNC_TILT_REPORT = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED  = 2'd0,
        STATUS_BUSY      = 2'd1,
        STATUS_BAD_ANGLE = 2'd2,
        STATUS_INFO      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        DRIVE_NONE = 3'd0,
        DRIVE_ABS  = 3'd1,
        DRIVE_HOME = 3'd2,
        DRIVE_STOP = 3'd3,
        DRIVE_JOG  = 3'd4
    } drive_kind_t;

    typedef enum logic [1:0] {
        DONE_NONE = 2'd0,
        DONE_PAN  = 2'd1,
        DONE_TILT = 2'd2,
        DONE_HOME = 2'd3
    } done_t;

    typedef enum logic [1:0] {
        MOVE_NONE = 2'd0,
        MOVE_PAN  = 2'd1,
        MOVE_TILT = 2'd2,
        MOVE_HOME = 2'd3
    } move_kind_t;

    localparam logic [1:0] CFG_PARK_PAN   = 2'd0;
    localparam logic [1:0] CFG_PARK_TILT  = 2'd1;
    localparam logic [1:0] CFG_PAN_OFFSET = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd3;

    localparam logic [11:0] PAN_OFFSET_RESET = 12'd2353;
    localparam logic [9:0]  THRESHOLD_RESET  = 10'd10;

    localparam logic signed [13:0] PAN_WRAP = 14'sd3600;

    localparam logic signed [8:0] PAN_ANGLE_MIN  = -9'sd180;
    localparam logic signed [8:0] PAN_ANGLE_MAX  = 9'sd180;
    localparam logic signed [8:0] TILT_ANGLE_MIN = -9'sd35;
    localparam logic signed [8:0] TILT_ANGLE_MAX = 9'sd40;

    localparam logic [1:0] ARR_PAN  = 2'b01;
    localparam logic [1:0] ARR_TILT = 2'b10;
    localparam logic [1:0] ARR_BOTH = 2'b11;

    typedef struct packed {
        logic [15:0]        park_pan;
        logic signed [15:0] park_tilt;
        logic [11:0]        pan_offset;
        logic [9:0]         arrive_threshold;
    } cfg_t;

    typedef struct packed {
        logic               busy;
        move_kind_t         move_kind;
        logic [15:0]        target_pan;
        logic signed [15:0] target_tilt;
        logic [1:0]         home_arrived;
        logic               notify;
        logic [15:0]        current_pan;
        logic signed [15:0] current_tilt;
    } trk_state_t;

    typedef struct packed {
        status_t            status;
        drive_kind_t        drive_kind;
        logic [15:0]        drive_pan;
        logic signed [15:0] drive_tilt;
        done_t              done_event;
        logic               busy_now;
        logic [15:0]        position_pan;
        logic signed [15:0] position_tilt;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/ptmt_step.sv @@
`default_nettype none

module ptmt_step (
    input  wire ptmt_pkg::cfg_t       cfg,
    input  wire ptmt_pkg::trk_state_t cur,
    input  wire ptmt_pkg::func_t      func,
    input  wire logic signed [8:0]    angle_deg,
    input  wire logic [15:0]          report_word,
    output ptmt_pkg::trk_state_t      nxt,
    output ptmt_pkg::result_t         res
);
    import ptmt_pkg::*;

    logic signed [12:0] angle_ext;
    logic signed [12:0] angle_x10;
    logic signed [13:0] pan_raw;
    logic signed [13:0] pan_wrapped;
    logic [15:0]        pan_target;
    logic signed [15:0] tilt_target;
    logic signed [16:0] pan_err;
    logic signed [16:0] tilt_err;
    logic [16:0]        pan_err_abs;
    logic [16:0]        tilt_err_abs;
    logic               pan_near;
    logic               tilt_near;
    logic               arrive_hit;
    logic [1:0]         arrive_bit;
    done_t              plain_event;

    assign angle_ext = {{4{angle_deg[8]}}, angle_deg};
    assign angle_x10 = (angle_ext <<< 3) + (angle_ext <<< 1);
    assign pan_raw   = $signed({2'b00, cfg.pan_offset}) + {angle_x10[12], angle_x10};

    always_comb begin
        if (pan_raw >= PAN_WRAP) begin
            pan_wrapped = pan_raw - PAN_WRAP;
        end else if (pan_raw < 14'sd0) begin
            pan_wrapped = pan_raw + PAN_WRAP;
        end else begin
            pan_wrapped = pan_raw;
        end
    end

    assign pan_target  = {4'b0000, pan_wrapped[11:0]};
    assign tilt_target = -{{3{angle_x10[12]}}, angle_x10};

    // compare against the new report, not the stored position
    assign pan_err  = $signed({1'b0, report_word}) - $signed({1'b0, cur.target_pan});
    assign tilt_err = $signed({report_word[15], report_word})
                    - {cur.target_tilt[15], cur.target_tilt};
    assign pan_err_abs  = pan_err[16]  ? 17'(-pan_err)  : 17'(pan_err);
    assign tilt_err_abs = tilt_err[16] ? 17'(-tilt_err) : 17'(tilt_err);
    assign pan_near  = pan_err_abs  <= {7'b0, cfg.arrive_threshold};
    assign tilt_near = tilt_err_abs <= {7'b0, cfg.arrive_threshold};

    always_comb begin
        nxt            = cur;
        res.status     = STATUS_INFO;
        res.drive_kind = DRIVE_NONE;
        res.drive_pan  = 16'd0;
        res.drive_tilt = 16'sd0;
        res.done_event = DONE_NONE;
        arrive_hit     = 1'b0;
        arrive_bit     = ARR_PAN;
        plain_event    = DONE_PAN;

        case (func)
            FUNC_HOME: begin
                if (cur.busy) begin
                    res.status = STATUS_BUSY;
                end else begin
                    nxt.target_pan   = cfg.park_pan;
                    nxt.target_tilt  = cfg.park_tilt;
                    nxt.notify       = 1'b1;
                    nxt.busy         = 1'b1;
                    nxt.home_arrived = 2'b00;
                    nxt.move_kind    = MOVE_HOME;
                    res.status       = STATUS_ACCEPTED;
                    res.drive_kind   = DRIVE_HOME;
                end
            end
            FUNC_STOP: begin
                nxt.notify     = 1'b0;
                nxt.busy       = 1'b0;
                res.drive_kind = DRIVE_STOP;
            end
            FUNC_JOG: begin
                if (cur.busy) begin
                    res.status = STATUS_BUSY;
                end else begin
                    nxt.notify     = 1'b0;
                    nxt.busy       = 1'b1;
                    res.status     = STATUS_ACCEPTED;
                    res.drive_kind = DRIVE_JOG;
                end
            end
            FUNC_PAN_ANGLE: begin
                if (cur.busy) begin
                    res.status = STATUS_BUSY;
                end else if (angle_deg < PAN_ANGLE_MIN || angle_deg > PAN_ANGLE_MAX) begin
                    res.status = STATUS_BAD_ANGLE;
                end else begin
                    nxt.notify     = 1'b1;
                    nxt.busy       = 1'b1;
                    nxt.move_kind  = MOVE_PAN;
                    nxt.target_pan = pan_target;
                    res.status     = STATUS_ACCEPTED;
                    res.drive_kind = DRIVE_ABS;
                    res.drive_pan  = pan_target;
                    res.drive_tilt = cur.current_tilt;
                end
            end
            FUNC_TILT_ANGLE: begin
                if (cur.busy) begin
                    res.status = STATUS_BUSY;
                end else if (angle_deg < TILT_ANGLE_MIN || angle_deg > TILT_ANGLE_MAX) begin
                    res.status = STATUS_BAD_ANGLE;
                end else begin
                    nxt.notify      = 1'b1;
                    nxt.busy        = 1'b1;
                    nxt.move_kind   = MOVE_TILT;
                    nxt.target_tilt = tilt_target;
                    res.status      = STATUS_ACCEPTED;
                    res.drive_kind  = DRIVE_ABS;
                    res.drive_pan   = cur.current_pan;
                    res.drive_tilt  = tilt_target;
                end
            end
            FUNC_PAN_REPORT: begin
                nxt.current_pan = report_word;
                arrive_hit      = cur.busy && pan_near;
                arrive_bit      = ARR_PAN;
                plain_event     = DONE_PAN;
            end
            FUNC_TILT_REPORT: begin
                nxt.current_tilt = $signed(report_word);
                arrive_hit       = cur.busy && tilt_near;
                arrive_bit       = ARR_TILT;
                plain_event      = DONE_TILT;
            end
            default: begin
            end
        endcase

        // homing ends only once both axes have checked in
        if (arrive_hit) begin
            if (cur.move_kind == MOVE_HOME) begin
                nxt.home_arrived = cur.home_arrived | arrive_bit;
                if (nxt.home_arrived == ARR_BOTH) begin
                    nxt.busy       = 1'b0;
                    res.done_event = cur.notify ? DONE_HOME : DONE_NONE;
                end
            end else begin
                nxt.busy       = 1'b0;
                res.done_event = cur.notify ? plain_event : DONE_NONE;
            end
        end

        res.busy_now      = nxt.busy;
        res.position_pan  = nxt.current_pan;
        res.position_tilt = nxt.current_tilt;
    end

endmodule

`default_nettype wire

@@ rtl/pan_tilt_move_tracker.sv @@
// An accepted word is held in the input register, its result word in the result register.
// Throughput: one word per cycle while m_tready is high; input register, one pass of move
// logic, result register. m_tready low with a result word waiting stalls both stages;
// s_tready stays high while the input stage can drain. Reset (aresetn low, synchronous):
// both stages empty, tracker idle, positions and targets zero, registers back to home 0/0,
// pan offset 2353, arrive threshold 10.
`default_nettype none

module pan_tilt_move_tracker (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // angle_deg[8:0], report_word[24:9], zero[31:25]
    input  wire logic [2:0]  s_tuser,   // func[2:0]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // drive_pan[15:0], drive_tilt[31:16],
                                        // done_event[33:32], busy_now[34],
                                        // position_pan[50:35], position_tilt[66:51],
                                        // zero[71:67]
    output logic [4:0]       m_tuser    // status[1:0], drive_kind[4:2]
);
    import ptmt_pkg::*;

    cfg_t               cfg_reg;
    trk_state_t         state_reg;
    trk_state_t         state_next;
    logic               in_valid_reg;
    func_t              in_func_reg;
    logic signed [8:0]  in_angle_reg;
    logic [15:0]        in_word_reg;
    logic               out_valid_reg;
    result_t            out_res_reg;
    result_t            res_next;
    logic               advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.park_pan         <= 16'd0;
            cfg_reg.park_tilt        <= 16'sd0;
            cfg_reg.pan_offset       <= PAN_OFFSET_RESET;
            cfg_reg.arrive_threshold <= THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PARK_PAN:   cfg_reg.park_pan         <= cfg_data;
                CFG_PARK_TILT:  cfg_reg.park_tilt        <= $signed(cfg_data);
                CFG_PAN_OFFSET: cfg_reg.pan_offset       <= cfg_data[11:0];
                CFG_THRESHOLD:  cfg_reg.arrive_threshold <= cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // move a word into the result stage when that stage is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg  <= func_t'(s_tuser);
            in_angle_reg <= $signed(s_tdata[8:0]);
            in_word_reg  <= s_tdata[24:9];
        end
    end

    ptmt_step u_step (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .func        (in_func_reg),
        .angle_deg   (in_angle_reg),
        .report_word (in_word_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_res_reg.drive_kind, out_res_reg.status};
    assign m_tdata  = {5'b00000,
                       out_res_reg.position_tilt,
                       out_res_reg.position_pan,
                       out_res_reg.busy_now,
                       out_res_reg.done_event,
                       out_res_reg.drive_tilt,
                       out_res_reg.drive_pan};

    a_accept_sets_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.status == STATUS_ACCEPTED) |-> out_res_reg.busy_now)
        else $error("accepted command left tracker idle");

    a_done_clears_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.done_event != DONE_NONE) |-> !out_res_reg.busy_now)
        else $error("done event while still busy");

    a_stop_clears_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.drive_kind == DRIVE_STOP) |-> !out_res_reg.busy_now)
        else $error("stop left tracker busy");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(state_reg))
        else $error("tracker state moved during output stall");

    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("empty input stage refused a word");

endmodule

`default_nettype wire
